### design/aibs_pkg.sv
// ----------------------------------------------------------------------------
// AXI INCR burst slave - shared types and constants
// Event kinds, error codes, phase codes and the records passed between parts.
// ----------------------------------------------------------------------------
package aibs_pkg;

  localparam int DATA_BYTES_DEF = 8;
  localparam int ADDR_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [2:0] ACT_RD_ADDR = 3'd0;
  localparam logic [2:0] ACT_RD_BEAT = 3'd1;
  localparam logic [2:0] ACT_WR_ADDR = 3'd2;
  localparam logic [2:0] ACT_WR_BEAT = 3'd3;
  localparam logic [2:0] ACT_RESP    = 3'd4;

  localparam logic [1:0] BURST_INCR = 2'd1;

  localparam logic       RP_IDLE = 1'b0;
  localparam logic       RP_DATA = 1'b1;
  localparam logic [1:0] WP_IDLE = 2'd0;
  localparam logic [1:0] WP_DATA = 2'd1;
  localparam logic [1:0] WP_RESP = 2'd2;

  typedef enum logic [2:0] {
    K_RD_ADDR,
    K_RD_BEAT,
    K_WR_ADDR,
    K_WR_BEAT,
    K_RESP,
    K_BAD
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_UNALIGNED = 3'd1,
    ERR_BURST     = 3'd2,
    ERR_NARROW    = 3'd3,
    ERR_EVENT     = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    err_e        chk;
    logic [31:0] address;
    logic [7:0]  burst_len;
    logic [63:0] write_data;
    logic [7:0]  write_strobe;
    logic        write_last;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [63:0] mem_write_data;
    logic [7:0]  mem_write_strobe;
    logic        read_last;
    logic        write_response;
    err_e        error;
  } res_t;

endpackage

### design/axi_incr_burst_slave_top.sv
// Items are registered in the command queue and results in the result queue.
// Throughput: one item per cycle while the result queue has room.
// Two-entry queues sit before and after the engine, so each side stalls alone.
// Reset (rst_ni low, asynchronous): both channels idle, pointers and beat
// count zero, both queues empty.
// ----------------------------------------------------------------------------
// AXI INCR burst slave - top level
// Event decoder, command queue, channel engine and result queue.
// ----------------------------------------------------------------------------
module axi_incr_burst_slave_top
  import aibs_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  burst_len_i,
  input  logic [2:0]  size_code_i,
  input  logic [1:0]  burst_type_i,
  input  logic [63:0] write_data_i,
  input  logic [7:0]  write_strobe_i,
  input  logic        write_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        accepted_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic [31:0] mem_address_o,
  output logic [63:0] mem_write_data_o,
  output logic [7:0]  mem_write_strobe_o,
  output logic        read_last_o,
  output logic        write_response_o,
  output logic [2:0]  error_o
);

  cmd_t cmd_in, cmd_head;
  res_t res_in, res_head;
  logic cmd_empty, res_full, step;

  aibs_front #(
    .DATA_BYTES(DATA_BYTES)
  ) u_front (
    .action_i      (action_i),
    .address_i     (address_i),
    .burst_len_i   (burst_len_i),
    .size_code_i   (size_code_i),
    .burst_type_i  (burst_type_i),
    .write_data_i  (write_data_i),
    .write_strobe_i(write_strobe_i),
    .write_last_i  (write_last_i),
    .cmd_o         (cmd_in)
  );

  aibs_fifo #(
    .item_t(cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (step),
    .empty_o(cmd_empty),
    .data_o (cmd_head)
  );

  aibs_back #(
    .DATA_BYTES(DATA_BYTES),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .res_full_i (res_full),
    .step_o     (step),
    .res_o      (res_in)
  );

  aibs_fifo #(
    .item_t(res_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_head)
  );

  assign accepted_o         = res_head.accepted;
  assign mem_read_o         = res_head.mem_read;
  assign mem_write_o        = res_head.mem_write;
  assign mem_address_o      = res_head.mem_address;
  assign mem_write_data_o   = res_head.mem_write_data;
  assign mem_write_strobe_o = res_head.mem_write_strobe;
  assign read_last_o        = res_head.read_last;
  assign write_response_o   = res_head.write_response;
  assign error_o            = res_head.error;

endmodule

### design/aibs_fifo.sv
// ----------------------------------------------------------------------------
// AXI INCR burst slave - small item queue
// Register-based FIFO with independent push and pop sides.
// ----------------------------------------------------------------------------
module aibs_fifo
  import aibs_pkg::*;
#(
  parameter type item_t = cmd_t,
  parameter int  DEPTH  = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/aibs_front.sv
// ----------------------------------------------------------------------------
// AXI INCR burst slave - event decoder
// Decodes the event kind and runs the burst checks of address events.
// ----------------------------------------------------------------------------
module aibs_front
  import aibs_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic [2:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  burst_len_i,
  input  logic [2:0]  size_code_i,
  input  logic [1:0]  burst_type_i,
  input  logic [63:0] write_data_i,
  input  logic [7:0]  write_strobe_i,
  input  logic        write_last_i,
  output cmd_t        cmd_o
);

  logic [7:0] bytes;
  logic [6:0] align_mask;
  kind_e      kind;
  err_e       chk;

  assign bytes      = 8'd1 << size_code_i;
  assign align_mask = 7'(bytes - 8'd1);

  always_comb begin
    unique case (action_i)
      ACT_RD_ADDR: kind = K_RD_ADDR;
      ACT_RD_BEAT: kind = K_RD_BEAT;
      ACT_WR_ADDR: kind = K_WR_ADDR;
      ACT_WR_BEAT: kind = K_WR_BEAT;
      ACT_RESP:    kind = K_RESP;
      default:     kind = K_BAD;
    endcase
  end

  always_comb begin
    priority if ((address_i[6:0] & align_mask) != 7'd0) begin
      chk = ERR_UNALIGNED;
    end else if (burst_type_i != BURST_INCR) begin
      chk = ERR_BURST;
    end else if (bytes != 8'(DATA_BYTES)) begin
      chk = ERR_NARROW;
    end else begin
      chk = ERR_NONE;
    end
  end

  always_comb begin
    cmd_o.kind         = kind;
    cmd_o.chk          = chk;
    cmd_o.address      = address_i;
    cmd_o.burst_len    = burst_len_i;
    cmd_o.write_data   = write_data_i;
    cmd_o.write_strobe = write_strobe_i;
    cmd_o.write_last   = write_last_i;
  end

endmodule

### design/aibs_back.sv
// ----------------------------------------------------------------------------
// AXI INCR burst slave - channel engine
// Holds the read and write phases and pointers and issues memory accesses.
// ----------------------------------------------------------------------------
module aibs_back
  import aibs_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF,
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  input  logic res_full_i,
  output logic step_o,
  output res_t res_o
);

  logic                  rp_q, rp_d;
  logic [1:0]            wp_q, wp_d;
  logic [7:0]            beats_q, beats_d;
  logic [ADDR_WIDTH-1:0] rptr_q, rptr_d;
  logic [ADDR_WIDTH-1:0] wptr_q, wptr_d;
  logic [ADDR_WIDTH-1:0] addr_m;
  logic [ADDR_WIDTH-1:0] rptr_inc;
  logic [ADDR_WIDTH-1:0] wptr_inc;

  assign step_o   = !cmd_empty_i && !res_full_i;
  assign addr_m   = ADDR_WIDTH'(cmd_i.address);
  assign rptr_inc = rptr_q + ADDR_WIDTH'(DATA_BYTES);
  assign wptr_inc = wptr_q + ADDR_WIDTH'(DATA_BYTES);

  always_comb begin
    rp_d    = rp_q;
    wp_d    = wp_q;
    beats_d = beats_q;
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    res_o   = '0;
    res_o.error = ERR_NONE;
    unique case (cmd_i.kind)
      K_RD_ADDR: begin
        if (rp_q != RP_IDLE) begin
          res_o.error = ERR_EVENT;
        end else if (cmd_i.chk != ERR_NONE) begin
          res_o.error = cmd_i.chk;
        end else begin
          res_o.accepted    = 1'b1;
          rp_d              = RP_DATA;
          beats_d           = cmd_i.burst_len;
          rptr_d            = addr_m;
          res_o.mem_read    = 1'b1;
          res_o.mem_address = 32'(addr_m);
          res_o.read_last   = (cmd_i.burst_len == 8'd0);
        end
      end
      K_RD_BEAT: begin
        if (rp_q != RP_DATA) begin
          res_o.error = ERR_EVENT;
        end else begin
          res_o.accepted = 1'b1;
          if (beats_q == 8'd0) begin
            rp_d = RP_IDLE;
          end else begin
            beats_d           = beats_q - 8'd1;
            rptr_d            = rptr_inc;
            res_o.mem_read    = 1'b1;
            res_o.mem_address = 32'(rptr_inc);
            res_o.read_last   = (beats_q == 8'd1);
          end
        end
      end
      K_WR_ADDR: begin
        if (wp_q != WP_IDLE) begin
          res_o.error = ERR_EVENT;
        end else if (cmd_i.chk != ERR_NONE) begin
          res_o.error = cmd_i.chk;
        end else begin
          res_o.accepted = 1'b1;
          wp_d           = WP_DATA;
          wptr_d         = addr_m;
        end
      end
      K_WR_BEAT: begin
        if (wp_q != WP_DATA) begin
          res_o.error = ERR_EVENT;
        end else begin
          res_o.accepted         = 1'b1;
          res_o.mem_write        = 1'b1;
          res_o.mem_address      = 32'(wptr_q);
          res_o.mem_write_data   = cmd_i.write_data;
          res_o.mem_write_strobe = cmd_i.write_strobe;
          if (cmd_i.write_last) begin
            wp_d                 = WP_RESP;
            res_o.write_response = 1'b1;
          end else begin
            wptr_d = wptr_inc;
          end
        end
      end
      K_RESP: begin
        if (wp_q != WP_RESP) begin
          res_o.error = ERR_EVENT;
        end else begin
          res_o.accepted = 1'b1;
          wp_d           = WP_IDLE;
        end
      end
      default: begin
        res_o.error = ERR_EVENT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= RP_IDLE;
      wp_q    <= WP_IDLE;
      beats_q <= '0;
      rptr_q  <= '0;
      wptr_q  <= '0;
    end else if (step_o) begin
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      beats_q <= beats_d;
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
    end
  end

endmodule

### design/aibs_checker.sv
// ----------------------------------------------------------------------------
// AXI INCR burst slave - port checker
// Consistency checks on the result items seen at the top-level ports.
// ----------------------------------------------------------------------------
module aibs_checker
  import aibs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       accepted_o,
  input logic       mem_read_o,
  input logic       mem_write_o,
  input logic       read_last_o,
  input logic       write_response_o,
  input logic [2:0] error_o
);

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(mem_read_o && mem_write_o))
    else $error("read and write issued by one item");

  a_acc_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (accepted_o == (error_o == ERR_NONE)))
    else $error("accepted flag disagrees with error code");

  a_rlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && read_last_o) |-> mem_read_o)
    else $error("read_last without a read");

  a_wresp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && write_response_o) |-> (mem_write_o && accepted_o))
    else $error("write response without a write beat");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result item withdrawn");

endmodule

bind axi_incr_burst_slave_top aibs_checker u_aibs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .accepted_o      (accepted_o),
  .mem_read_o      (mem_read_o),
  .mem_write_o     (mem_write_o),
  .read_last_o     (read_last_o),
  .write_response_o(write_response_o),
  .error_o         (error_o)
);
